### rtl/wmm_pkg.sv
// Shared types and constants of the Winograd matrix multiply unit.
package wmm_pkg;

   localparam int MAX_DIM_DEF    = 32;
   localparam int ELEM_WIDTH_DEF = 16;
   localparam int DIM_W          = 6;
   localparam int IDX_W          = 5;
   localparam int VAL_W          = 16;
   localparam int ACC_W          = 32;
   localparam int CSR_IDX_W      = 2;

   typedef enum logic [1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_B  = 2'd1,
      CMD_PREPARE = 2'd2,
      CMD_ROW     = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROWS_A    = 2'd0,
      REG_INNER_DIM = 2'd1,
      REG_COLS_B    = 2'd2,
      REG_UNUSED    = 2'd3
   } csr_index_type;

   // what a sequencer step works on
   typedef enum logic [1:0] {
      KIND_MAIN = 2'd0,
      KIND_ROWF = 2'd1,
      KIND_COLF = 2'd2,
      KIND_ACK  = 2'd3
   } kind_type;

   typedef struct packed {
      logic             vld;
      logic             use_a;
      logic             use_b;
      logic             phase;
      logic             first;
      logic             fin;
      kind_type         kind;
      logic [IDX_W-1:0] idx;
      logic             last;
   } step_tag_type;

   typedef struct packed {
      logic busy;
      logic fin_busy;
   } mac_status_type;

endpackage

### rtl/wmm_ifs.sv
// Handshake channel interfaces: request, response and register write.
interface wmm_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                cmd;
   logic [wmm_pkg::IDX_W-1:0] row;
   logic [wmm_pkg::IDX_W-1:0] col;
   logic signed [wmm_pkg::VAL_W-1:0] value;
   modport source (output valid, cmd, row, col, value, input ready);
   modport sink (input valid, cmd, row, col, value, output ready);
endinterface

interface wmm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [wmm_pkg::IDX_W-1:0] out_row;
   logic [wmm_pkg::IDX_W-1:0] out_col;
   logic signed [wmm_pkg::ACC_W-1:0] product;
   logic                      last;
   modport source (output valid, out_row, out_col, product, last, input ready);
   modport sink (input valid, out_row, out_col, product, last, output ready);
endinterface

interface wmm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [wmm_pkg::CSR_IDX_W-1:0] index;
   logic [wmm_pkg::DIM_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/winograd_matrix_multiply_unit.sv
// Winograd matrix multiply unit: operand stores, sequencer and result register.
// Loads write the addressed operand store when accepted; prepare fills the factor tables, then acks.
// Row: with t = m/2 + m%2 terms, one result per column of B for the requested row,
// its terms read over one read port per operand store; the row's last result is marked last.
// Requests are taken only when idle and drained; a held response stalls the sequencer.
// Synchronous reset: dimensions 32, control cleared, factors read as zero until prepared.
module winograd_matrix_multiply_unit #(
   parameter int MAX_DIM    = wmm_pkg::MAX_DIM_DEF,
   parameter int ELEM_WIDTH = wmm_pkg::ELEM_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   wmm_req_if.sink    req_bus,
   wmm_rsp_if.source  rsp_bus,
   wmm_csr_if.sink    csr_bus
);

   localparam int AW        = $clog2(MAX_DIM * MAX_DIM);
   localparam int FW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DIM_LIMIT = (MAX_DIM < 32) ? MAX_DIM : 32;
   localparam int DW        = wmm_pkg::DIM_W;
   localparam int XW        = wmm_pkg::IDX_W;
   localparam int CW        = wmm_pkg::ACC_W;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   // configuration
   logic [DW-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DW-1:0] n_dim, m_dim, q_dim;
   logic [XW-1:0] half;
   logic [XW-1:0] nterms;

   function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
      if (v == '0) return DW'(1);
      if (v > DW'(DIM_LIMIT)) return DW'(DIM_LIMIT);
      return v;
   endfunction

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DW'(32);
         inner_dim_ff <= DW'(32);
         cols_b_ff    <= DW'(32);
      end else if (csr_bus.valid) begin
         unique case (wmm_pkg::csr_index_type'(csr_bus.index))
            wmm_pkg::REG_ROWS_A:    rows_a_ff    <= csr_bus.data;
            wmm_pkg::REG_INNER_DIM: inner_dim_ff <= csr_bus.data;
            wmm_pkg::REG_COLS_B:    cols_b_ff    <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // sequencer
   state_type          state_ff, state_in;
   wmm_pkg::kind_type  kind_ff, kind_in;
   logic [XW-1:0]      r_ff, r_in;
   logic [DW-1:0]      o_ff, o_in;
   logic [XW-1:0]      k_ff, k_in;
   logic               ph_ff, ph_in;
   logic               fin_ff, fin_in;
   wmm_pkg::step_tag_type tag0, tag1_ff, tag3;
   wmm_pkg::mac_status_type mac_status;
   logic [CW-1:0]      acc3;
   logic               busy, out_ok, issue, req_acc, tail, in_range;
   logic [DW-1:0]      cnt;
   logic [DW-1:0]      a_row, a_col, b_row, b_col, k2;
   logic [AW-1:0]      a_raddr, b_raddr, wr_addr;

   // response register
   logic               rsp_valid_ff;
   logic [XW-1:0]      rsp_row_ff, rsp_col_ff;
   logic [CW-1:0]      rsp_prod_ff;
   logic               rsp_last_ff;

   always_comb begin
      n_dim  = clamp_dim(rows_a_ff);
      m_dim  = clamp_dim(inner_dim_ff);
      q_dim  = clamp_dim(cols_b_ff);
      half   = XW'(m_dim >> 1);
      nterms = (kind_ff == wmm_pkg::KIND_MAIN) ? XW'(half + XW'(m_dim[0])) : half;
      cnt    = (kind_ff == wmm_pkg::KIND_ROWF) ? n_dim : q_dim;
   end

   assign busy          = tag1_ff.vld || mac_status.busy;
   assign req_bus.ready = (state_ff == ST_IDLE) && !busy;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign out_ok        = (!rsp_valid_ff || rsp_bus.ready) && !mac_status.fin_busy
                          && !(tag1_ff.vld && tag1_ff.fin);
   assign in_range      = (32'(req_bus.row) < MAX_DIM) && (32'(req_bus.col) < MAX_DIM);

   always_comb begin
      if (!fin_ff) begin
         issue = 1'b1;
      end else if (kind_ff == wmm_pkg::KIND_MAIN || kind_ff == wmm_pkg::KIND_ACK) begin
         issue = out_ok;
      end else begin
         issue = 1'b1;
      end
      issue = issue && (state_ff == ST_RUN);
      tail  = (kind_ff == wmm_pkg::KIND_MAIN) && m_dim[0] && (k_ff == half);
      k2    = DW'({k_ff, 1'b0});

      tag0.vld   = issue;
      tag0.phase = ph_ff;
      tag0.fin   = fin_ff;
      tag0.first = fin_ff ? (nterms == '0) : ((k_ff == '0) && !ph_ff);
      tag0.kind  = kind_ff;
      tag0.idx   = XW'(o_ff);
      tag0.last  = (kind_ff == wmm_pkg::KIND_ACK) || (o_ff == cnt - DW'(1));
      unique case (kind_ff)
         wmm_pkg::KIND_MAIN: begin
            tag0.use_a = !tail || !ph_ff;
            tag0.use_b = !tail || ph_ff;
         end
         wmm_pkg::KIND_ROWF: begin
            tag0.use_a = 1'b1;
            tag0.use_b = 1'b0;
         end
         default: begin
            tag0.use_a = 1'b0;
            tag0.use_b = (kind_ff == wmm_pkg::KIND_COLF);
         end
      endcase

      a_row = (kind_ff == wmm_pkg::KIND_MAIN) ? DW'(r_ff) : o_ff;
      a_col = k2 + DW'(ph_ff);
      b_row = (kind_ff == wmm_pkg::KIND_MAIN) ? (k2 + DW'(!ph_ff)) : (k2 + DW'(ph_ff));
      b_col = o_ff;
      a_raddr = AW'(32'(a_row) * MAX_DIM + 32'(a_col));
      b_raddr = AW'(32'(b_row) * MAX_DIM + 32'(b_col));
      wr_addr = AW'(32'(req_bus.row) * MAX_DIM + 32'(req_bus.col));
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      r_in     = r_ff;
      o_in     = o_ff;
      k_in     = k_ff;
      ph_in    = ph_ff;
      fin_in   = fin_ff;
      if (state_ff == ST_IDLE) begin
         if (req_acc && req_bus.cmd == wmm_pkg::CMD_PREPARE) begin
            state_in = ST_RUN;
            kind_in  = wmm_pkg::KIND_ROWF;
            o_in     = '0;
            k_in     = '0;
            ph_in    = 1'b0;
            fin_in   = (half == '0);
         end else if (req_acc && req_bus.cmd == wmm_pkg::CMD_ROW
                      && DW'(req_bus.row) < n_dim) begin
            state_in = ST_RUN;
            kind_in  = wmm_pkg::KIND_MAIN;
            r_in     = req_bus.row;
            o_in     = '0;
            k_in     = '0;
            ph_in    = 1'b0;
            fin_in   = 1'b0;
         end
      end else if (issue) begin
         if (!fin_ff) begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (k_ff == nterms - XW'(1)) begin
                  fin_in = 1'b1;
               end else begin
                  k_in = k_ff + XW'(1);
               end
            end
         end else begin
            k_in  = '0;
            ph_in = 1'b0;
            if (kind_ff == wmm_pkg::KIND_ACK || o_ff == cnt - DW'(1)) begin
               o_in = '0;
               priority case (kind_ff)
                  wmm_pkg::KIND_ROWF: begin
                     kind_in = wmm_pkg::KIND_COLF;
                     fin_in  = (half == '0);
                  end
                  wmm_pkg::KIND_COLF: begin
                     kind_in = wmm_pkg::KIND_ACK;
                     fin_in  = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                     fin_in   = 1'b0;
                  end
               endcase
            end else begin
               o_in   = o_ff + DW'(1);
               fin_in = (nterms == '0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= wmm_pkg::KIND_MAIN;
         fin_ff   <= 1'b0;
         ph_ff    <= 1'b0;
         k_ff     <= '0;
         o_ff     <= '0;
         r_ff     <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         fin_ff   <= fin_in;
         ph_ff    <= ph_in;
         k_ff     <= k_in;
         o_ff     <= o_in;
         r_ff     <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.vld <= 1'b0;
      end else begin
         tag1_ff.vld <= tag0.vld;
      end
      tag1_ff[$bits(tag1_ff)-2:0] <= tag0[$bits(tag0)-2:0];
   end

   // operand stores
   logic [ELEM_WIDTH-1:0]        a_mem [MAX_DIM*MAX_DIM];
   logic [ELEM_WIDTH-1:0]        b_mem [MAX_DIM*MAX_DIM];
   logic signed [ELEM_WIDTH-1:0] a_rd_ff, b_rd_ff;
   logic [CW-1:0]                load_val;

   assign load_val = CW'(req_bus.value);

   always_ff @(posedge clock) begin
      if (req_acc && req_bus.cmd == wmm_pkg::CMD_LOAD_A && in_range) begin
         a_mem[wr_addr] <= ELEM_WIDTH'(load_val);
      end
      a_rd_ff <= a_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_bus.cmd == wmm_pkg::CMD_LOAD_B && in_range) begin
         b_mem[wr_addr] <= ELEM_WIDTH'(load_val);
      end
      b_rd_ff <= b_mem[b_raddr];
   end

   // factor tables
   logic [CW-1:0]      rf_mem [MAX_DIM];
   logic [CW-1:0]      cf_mem [MAX_DIM];
   logic [CW-1:0]      rf_rd_ff, cf_rd_ff;
   logic [MAX_DIM-1:0] rf_vld_ff, cf_vld_ff;
   logic               rf_hit_ff, cf_hit_ff;
   logic [CW-1:0]      rf_q, cf_q;
   logic               fin3;

   assign fin3 = tag3.vld && tag3.fin;

   always_ff @(posedge clock) begin
      if (fin3 && tag3.kind == wmm_pkg::KIND_ROWF) begin
         rf_mem[FW'(tag3.idx)] <= acc3;
      end
      rf_rd_ff <= rf_mem[FW'(r_ff)];
   end

   always_ff @(posedge clock) begin
      if (fin3 && tag3.kind == wmm_pkg::KIND_COLF) begin
         cf_mem[FW'(tag3.idx)] <= acc3;
      end
      cf_rd_ff <= cf_mem[FW'(o_ff)];
   end

   // a factor reads as zero until its first prepare
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
         cf_vld_ff <= '0;
      end else if (fin3) begin
         if (tag3.kind == wmm_pkg::KIND_ROWF) begin
            rf_vld_ff[FW'(tag3.idx)] <= 1'b1;
         end
         if (tag3.kind == wmm_pkg::KIND_COLF) begin
            cf_vld_ff[FW'(tag3.idx)] <= 1'b1;
         end
      end
      rf_hit_ff <= rf_vld_ff[FW'(r_ff)];
      cf_hit_ff <= cf_vld_ff[FW'(o_ff)];
   end

   assign rf_q = rf_hit_ff ? rf_rd_ff : '0;
   assign cf_q = cf_hit_ff ? cf_rd_ff : '0;

   wmm_mac #(
      .ELEM_WIDTH(ELEM_WIDTH)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .tag1    (tag1_ff),
      .a_data  (a_rd_ff),
      .b_data  (b_rd_ff),
      .rf_data (rf_q),
      .cf_data (cf_q),
      .tag_out (tag3),
      .acc_out (acc3),
      .status  (mac_status)
   );

   // result register; the sequencer holds a final row or ack step until this slot is free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin3 && (tag3.kind == wmm_pkg::KIND_MAIN
                            || tag3.kind == wmm_pkg::KIND_ACK)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fin3 && tag3.kind == wmm_pkg::KIND_MAIN) begin
         rsp_row_ff  <= r_ff;
         rsp_col_ff  <= tag3.idx;
         rsp_prod_ff <= acc3;
         rsp_last_ff <= tag3.last;
      end else if (fin3 && tag3.kind == wmm_pkg::KIND_ACK) begin
         rsp_row_ff  <= '0;
         rsp_col_ff  <= '0;
         rsp_prod_ff <= '0;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.out_row = rsp_row_ff;
   assign rsp_bus.out_col = rsp_col_ff;
   assign rsp_bus.product = rsp_prod_ff;
   assign rsp_bus.last    = rsp_last_ff;

endmodule

### rtl/wmm_mac.sv
// Operand add, multiply and accumulate pipeline behind the store reads.
module wmm_mac #(
   parameter int ELEM_WIDTH = wmm_pkg::ELEM_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  wmm_pkg::step_tag_type             tag1,
   input  logic signed [ELEM_WIDTH-1:0]      a_data,
   input  logic signed [ELEM_WIDTH-1:0]      b_data,
   input  logic [wmm_pkg::ACC_W-1:0]         rf_data,
   input  logic [wmm_pkg::ACC_W-1:0]         cf_data,
   output wmm_pkg::step_tag_type             tag_out,
   output logic [wmm_pkg::ACC_W-1:0]         acc_out,
   output wmm_pkg::mac_status_type           status
);

   wmm_pkg::step_tag_type       tag2_ff, tag3_ff;
   logic [wmm_pkg::ACC_W-1:0]   x_ff, opx_ff, opy_ff, prod_ff, acc_ff;
   logic [wmm_pkg::ACC_W-1:0]   init2_ff, init3_ff;
   logic [wmm_pkg::ACC_W-1:0]   a_ext, b_ext, opsum, init_in, acc_cur, acc_in;
   logic                        prod_vld;

   always_comb begin
      a_ext = tag1.use_a ? wmm_pkg::ACC_W'(a_data) : '0;
      b_ext = tag1.use_b ? wmm_pkg::ACC_W'(b_data) : '0;
      opsum = a_ext + b_ext;
      init_in = (tag1.kind == wmm_pkg::KIND_MAIN) ? ('0 - (rf_data + cf_data)) : '0;
   end

   always_comb begin
      prod_vld = tag3_ff.vld && tag3_ff.phase && !tag3_ff.fin;
      acc_cur  = tag3_ff.first ? init3_ff : acc_ff;
      acc_in   = acc_cur + (prod_vld ? prod_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff.vld <= 1'b0;
         tag3_ff.vld <= 1'b0;
      end else begin
         tag2_ff.vld <= tag1.vld;
         tag3_ff.vld <= tag2_ff.vld;
      end
      tag2_ff[$bits(tag2_ff)-2:0] <= tag1[$bits(tag1)-2:0];
      tag3_ff[$bits(tag3_ff)-2:0] <= tag2_ff[$bits(tag2_ff)-2:0];
      init2_ff <= init_in;
      init3_ff <= init2_ff;
      if (tag1.vld && !tag1.fin && !tag1.phase) begin
         x_ff <= opsum;
      end
      if (tag1.vld && !tag1.fin && tag1.phase) begin
         opx_ff <= x_ff;
         opy_ff <= opsum;
      end
      prod_ff <= opx_ff * opy_ff;
      if (tag3_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   assign tag_out         = tag3_ff;
   assign acc_out         = acc_cur;
   assign status.busy     = tag2_ff.vld || tag3_ff.vld;
   assign status.fin_busy = (tag2_ff.vld && tag2_ff.fin) || (tag3_ff.vld && tag3_ff.fin);

endmodule
